[rtl/core/address_tracking_table_lru_aging_assert.svh]
// Assertion macros shared by the address tracking table RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ADDRESS_TRACKING_TABLE_LRU_AGING_ASSERT_SVH
`define ADDRESS_TRACKING_TABLE_LRU_AGING_ASSERT_SVH
`ifndef SYNTH
// Plain property that must hold on every clock edge out of reset.
`define ATL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("atl assertion failed");
// Same-cycle implication.
`define ATL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atl implication failed");
`else
`define ATL_ASSERT(lbl, clk, rst, prop)
`define ATL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/atl_pkg.sv]
// Shared types and codes for the address tracking table.
// No dependencies; imported by atl_front, atl_back and the top level.
package atl_pkg;

  // Number of table slots; the slot and occupancy ports are sized for this value.
  localparam int MAX_ENTRIES = 32;

  localparam logic [1:0] REQ_OBSERVE = 2'd0;
  localparam logic [1:0] REQ_LOOKUP  = 2'd1;
  localparam logic [1:0] REQ_SWEEP   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [3:0] KIND_UNKNOWN = 4'd0;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_SWEEP   = 2'd2,
    OP_REJECT  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [47:0] mac;
    logic [3:0]  dev_type;
    logic [31:0] ts;
  } item_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [3:0]  kind;
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/core/atl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[rtl/core/atl_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on atl_pkg.
module atl_front import atl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [47:0] mac,
  input  logic [3:0]  dev_type,
  input  logic [31:0] timestamp,
  output logic        q_valid,
  input  logic        q_pop,
  output item_t       q_item
);
  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  item_t      cls;
  logic       push;

  // Classification: an observe of unknown kind and the unused code are rejected up front.
  always_comb begin
    cls.mac      = mac;
    cls.dev_type = dev_type;
    cls.ts       = timestamp;
    unique case (req_type)
      REQ_OBSERVE: cls.op = (dev_type == KIND_UNKNOWN) ? OP_REJECT : OP_OBSERVE;
      REQ_LOOKUP:  cls.op = OP_LOOKUP;
      REQ_SWEEP:   cls.op = OP_SWEEP;
      default:     cls.op = OP_REJECT;
    endcase
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end
endmodule

[rtl/core/atl_back.sv]
// Back end: scans the table for each queued request that is not rejected and produces the result.
// Depends on atl_pkg, atl_ram and the assertion macro header.
`include "address_tracking_table_lru_aging_assert.svh"
module atl_back import atl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] limit,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  slot,
  output logic        is_new,
  output logic        evicted,
  output logic [3:0]  entry_kind,
  output logic [31:0] first_time,
  output logic [31:0] last_time,
  output logic [31:0] seen_count,
  output logic [5:0]  occupancy,
  output logic [5:0]  removed_count
);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                 state;
  item_t                  item;
  logic [MAX_ENTRIES-1:0] slot_valid;
  logic [CW-1:0]          valid_total;
  logic [CW-1:0]          removed;
  logic [IW-1:0]          cnt;
  logic                   issuing;
  logic                   pv;
  logic [IW-1:0]          pidx;
  logic                   hit;
  logic [IW-1:0]          hit_idx;
  entry_t                 cap;
  logic                   has_free;
  logic [IW-1:0]          free_idx;
  logic                   has_old;
  logic [IW-1:0]          old_idx;
  logic [31:0]            old_time;

  logic                   rd_en;
  logic [ENTRY_W-1:0]     rd_raw;
  entry_t                 rd_data;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  entry_t                 wr_data;

  logic                   v_cur;
  logic                   is_match;
  logic                   is_free;
  logic                   is_older;
  logic                   is_stale;
  logic [31:0]            age;
  logic                   out_free;
  logic                   finish;

  logic [1:0]             status_next;
  logic [4:0]             slot_next;
  logic                   is_new_next;
  logic                   evicted_next;
  logic [3:0]             entry_kind_next;
  logic [31:0]            first_time_next;
  logic [31:0]            last_time_next;
  logic [31:0]            seen_count_next;
  logic [5:0]             occupancy_next;
  logic [5:0]             removed_count_next;
  logic [CW-1:0]          valid_total_next;

  atl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_raw)
  );

  assign rd_data  = entry_t'(rd_raw);
  assign rd_en    = (state == S_SCAN) && issuing;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == S_FIN) && out_free;

  // Per-entry classification of the word coming back from the RAM.
  always_comb begin
    v_cur    = slot_valid[pidx];
    age      = item.ts - rd_data.last;
    is_match = pv && v_cur && !hit && (rd_data.mac == item.mac);
    is_free  = pv && !v_cur && !has_free;
    is_older = pv && v_cur && (!has_old || (rd_data.last < old_time));
    is_stale = pv && v_cur && (item.op == OP_SWEEP) && (age > limit);
  end

  // Write-back for an observe: refresh a hit, otherwise fill a free or the oldest slot.
  always_comb begin
    wr_en = finish && (item.op == OP_OBSERVE);
    if (hit) begin
      wr_addr       = hit_idx;
      wr_data       = cap;
      wr_data.last  = item.ts;
      wr_data.count = cap.count + 32'd1;
    end else begin
      wr_addr       = has_free ? free_idx : old_idx;
      wr_data.mac   = item.mac;
      wr_data.kind  = item.dev_type;
      wr_data.first = item.ts;
      wr_data.last  = item.ts;
      wr_data.count = 32'd1;
    end
  end

  // Result of the finished item; fields that do not apply stay at zero.
  always_comb begin
    status_next        = ST_OK;
    slot_next          = '0;
    is_new_next        = 1'b0;
    evicted_next       = 1'b0;
    entry_kind_next    = '0;
    first_time_next    = '0;
    last_time_next     = '0;
    seen_count_next    = '0;
    removed_count_next = '0;
    valid_total_next   = valid_total;
    unique case (item.op)
      OP_OBSERVE: begin
        slot_next       = 5'(wr_addr);
        is_new_next     = !hit;
        evicted_next    = !hit && !has_free;
        entry_kind_next = wr_data.kind;
        first_time_next = wr_data.first;
        last_time_next  = wr_data.last;
        seen_count_next = wr_data.count;
        if (!hit && has_free) begin
          valid_total_next = valid_total + 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          slot_next       = 5'(hit_idx);
          entry_kind_next = cap.kind;
          first_time_next = cap.first;
          last_time_next  = cap.last;
          seen_count_next = cap.count;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_SWEEP: begin
        removed_count_next = 6'(removed);
      end
      default: begin
        status_next = ST_BAD_TYPE;
      end
    endcase
    occupancy_next = 6'(valid_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      valid_total <= '0;
      out_valid   <= 1'b0;
      issuing     <= 1'b0;
      pv          <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !finish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item     <= q_item;
            cnt      <= '0;
            hit      <= 1'b0;
            has_free <= 1'b0;
            has_old  <= 1'b0;
            removed  <= '0;
            issuing  <= (q_item.op != OP_REJECT);
            state    <= (q_item.op == OP_REJECT) ? S_FIN : S_SCAN;
          end
        end
        S_SCAN: begin
          pv   <= issuing;
          pidx <= cnt;
          if (issuing) begin
            if (cnt == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
          if (is_match) begin
            hit     <= 1'b1;
            hit_idx <= pidx;
            cap     <= rd_data;
          end
          if (is_free) begin
            has_free <= 1'b1;
            free_idx <= pidx;
          end
          if (is_older) begin
            has_old  <= 1'b1;
            old_idx  <= pidx;
            old_time <= rd_data.last;
          end
          if (is_stale) begin
            slot_valid[pidx] <= 1'b0;
            valid_total      <= valid_total - 1'b1;
            removed          <= removed + 1'b1;
          end
          if (pv && (pidx == LAST_IDX)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            state         <= S_IDLE;
            status        <= status_next;
            slot          <= slot_next;
            is_new        <= is_new_next;
            evicted       <= evicted_next;
            entry_kind    <= entry_kind_next;
            first_time    <= first_time_next;
            last_time     <= last_time_next;
            seen_count    <= seen_count_next;
            occupancy     <= occupancy_next;
            removed_count <= removed_count_next;
            valid_total   <= valid_total_next;
            if (item.op == OP_OBSERVE) begin
              slot_valid[wr_addr] <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ATL_ASSERT(a_count_matches_bits, clk, rst, valid_total == CW'($countones(slot_valid)))
  `ATL_ASSERT(a_count_bounded, clk, rst, valid_total <= CW'(MAX_ENTRIES))
  `ATL_ASSERT_IMP(a_evict_is_new, clk, rst, out_valid && evicted, is_new && status == ST_OK)
  `ATL_ASSERT_IMP(a_result_from_fin, clk, rst, $rose(out_valid), $past(state) == S_FIN)
endmodule

[rtl/core/address_tracking_table_lru_aging.sv]
// Top level of the address tracking table with oldest-entry eviction and aging.
// Depends on atl_pkg, atl_front, atl_back and atl_ram.
//
// Usage. Requests arrive on the input channel (in_valid / in_stall) with the
// fields req_type, mac, dev_type and timestamp; a transfer takes place at a
// rising edge where in_valid is high and in_stall is low. Every request gives
// exactly one result on the output channel (out_valid / out_stall), in order.
// The front end classifies each request and places it in a two-deep queue;
// the back end walks every table slot through one RAM read port, one slot a
// cycle, and takes the next item from the queue only once the result of the
// last one has been registered; a rejected request skips the table walk.
// The user writes the stale_timeout register (cfg_wr_en / cfg_wr_data) only
// while the block is idle; the block does not enforce this. Zero selects
// DEFAULT_TIMEOUT for sweeps. Reset (rst, synchronous, active high) empties
// the queue, marks every slot free and clears the timeout. When the receiver
// stalls, the result is held steady in the output register; the back end
// waits, and once the queue is full the input channel stalls as well.
module address_tracking_table_lru_aging import atl_pkg::*; #(
  parameter int DEFAULT_TIMEOUT = 300
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [47:0] mac,
  input  logic [3:0]  dev_type,
  input  logic [31:0] timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  slot,
  output logic        is_new,
  output logic        evicted,
  output logic [3:0]  entry_kind,
  output logic [31:0] first_time,
  output logic [31:0] last_time,
  output logic [31:0] seen_count,
  output logic [5:0]  occupancy,
  output logic [5:0]  removed_count
);
  logic [31:0] stale_timeout;
  logic [31:0] limit;
  logic        q_valid;
  logic        q_pop;
  item_t       q_item;

  // The timeout register; a zero value falls back to the default age limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_timeout <= '0;
    end else if (cfg_wr_en) begin
      stale_timeout <= cfg_wr_data;
    end
  end

  assign limit = (stale_timeout == 32'd0) ? 32'(DEFAULT_TIMEOUT) : stale_timeout;

  atl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .mac       (mac),
    .dev_type  (dev_type),
    .timestamp (timestamp),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  atl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .limit         (limit),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .slot          (slot),
    .is_new        (is_new),
    .evicted       (evicted),
    .entry_kind    (entry_kind),
    .first_time    (first_time),
    .last_time     (last_time),
    .seen_count    (seen_count),
    .occupancy     (occupancy),
    .removed_count (removed_count)
  );
endmodule
